@@ sv/kch_pkg.sv @@
`default_nettype none

package kch_pkg;

  localparam int unsigned FieldW = 20;
  localparam int unsigned CountW = 15;
  localparam int unsigned SeedW  = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 15;

  localparam logic [CountW-1:0] HardCountCap = CountW'(1024 * 16);
  localparam logic [SeedW-1:0]  SeedRst      = SeedW'(10);
  localparam logic [CountW-1:0] LimitRst     = CountW'(16384);

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEED_LENGTH = 1'b0,
    CFG_COUNT_LIMIT = 1'b1
  } cfg_index_e;

  typedef struct packed {
    action_e           action;
    logic [1:0]        base_code;
    logic              sequence_start;
    logic [FieldW-1:0] entry_index;
  } kch_in_t;

  typedef struct packed {
    logic              kmer_valid;
    logic [FieldW-1:0] kmer_code;
    logic [CountW-1:0] count_value;
    logic              at_limit;
  } kch_out_t;

endpackage

`default_nettype wire

@@ sv/kmer_count_histogram_unit.sv @@
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_data_i   (kch_in_t)
// out       output     out_valid_o / out_ready_i out_data_o  (kch_out_t)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One transfer per cycle unless the output stalls; a result passes the modify
// stage and the output register. The count table is a single-port-write
// memory with a registered read; each item reads at acceptance and writes
// back on leaving the modify stage, with the last write forwarded. After
// reset a clearing pass zeroes the table, during which in_ready_o stays low.
// A stalled output holds the item in the modify stage; nothing is dropped.
`default_nettype none

module kmer_count_histogram_unit #(
  parameter int unsigned MAX_SEED = 10
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  kch_pkg::kch_in_t           in_data_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output kch_pkg::kch_out_t          out_data_o,
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire [kch_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire [kch_pkg::CfgDataW-1:0] cfg_data_i
);
  import kch_pkg::*;

  localparam int unsigned AddrW = 2 * MAX_SEED;
  localparam logic [SeedW-1:0] MaxSeed = SeedW'(MAX_SEED);
  localparam logic [SeedW-1:0] SeedRstEff = (SeedRst > MaxSeed) ? MaxSeed : SeedRst;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  logic [CountW-1:0] mem [2**AddrW];

  logic [SeedW-1:0]  seed_q;
  logic [CountW-1:0] limit_q;
  logic [AddrW-1:0]  shift_q, shift_d;
  logic [SeedW-1:0]  seen_q, seen_d;
  logic              clr_busy_q;
  logic [AddrW-1:0]  clr_addr_q;

  logic              s1_valid_q;
  op_e               s1_op_q, op_d;
  logic [AddrW-1:0]  s1_addr_q, rd_addr;
  logic [CountW-1:0] rdata_q;

  logic              fwd_valid_q;
  logic [AddrW-1:0]  fwd_addr_q;
  logic [CountW-1:0] fwd_data_q;

  logic              out_valid_q;
  kch_out_t          out_q, res;

  logic              in_fire, s1_fire, s1_write;
  logic [AddrW:0]    mask_full;
  logic [CountW-1:0] cur, new_cnt;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [CountW-1:0] wr_data;
  logic [SeedW-1:0]  cfg_seed;
  logic [CountW-1:0] cfg_limit;

  assign cfg_ready_o = 1'b1;
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !clr_busy_q && (!s1_valid_q || s1_fire);
  assign in_fire     = in_valid_i && in_ready_o;

  // rolling k-mer and address for the table read
  always_comb begin
    shift_d   = shift_q;
    seen_d    = seen_q;
    op_d      = OP_NONE;
    rd_addr   = AddrW'(in_data_i.entry_index);
    mask_full = ({{AddrW{1'b0}}, 1'b1} << {seed_q, 1'b0}) - 1'b1;
    case (in_data_i.action)
      ACT_ADD: begin
        if (in_data_i.sequence_start) begin
          shift_d = AddrW'(in_data_i.base_code);
          seen_d = SeedW'(1);
        end else begin
          shift_d = AddrW'({shift_q, in_data_i.base_code});
          seen_d  = (seen_q < MaxSeed) ? seen_q + 1'b1 : seen_q;
        end
        rd_addr = shift_d & mask_full[AddrW-1:0];
        op_d    = (seen_d >= seed_q) ? OP_COUNT : OP_NONE;
      end
      ACT_READ:  op_d = OP_READ;
      ACT_CLEAR: op_d = OP_CLEAR;
      default:   op_d = OP_NONE;
    endcase
  end

  // modify stage
  always_comb begin
    cur = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rdata_q;
    new_cnt  = (cur < limit_q) ? cur + 1'b1 : cur;
    s1_write = 1'b0;
    res      = '0;
    case (s1_op_q)
      OP_COUNT: begin
        s1_write        = 1'b1;
        res.kmer_valid  = 1'b1;
        res.kmer_code   = FieldW'(s1_addr_q);
        res.count_value = new_cnt;
      end
      OP_READ: begin
        res.kmer_valid  = 1'b1;
        res.kmer_code   = FieldW'(s1_addr_q);
        res.count_value = cur;
      end
      OP_CLEAR: begin
        s1_write        = 1'b1;
        new_cnt         = '0;
        res.kmer_valid  = 1'b1;
        res.kmer_code   = FieldW'(s1_addr_q);
      end
      default: res = '0;
    endcase
    res.at_limit = res.kmer_valid && (res.count_value == limit_q);
  end

  always_comb begin
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else begin
      wr_en   = s1_fire && s1_write;
      wr_addr = s1_addr_q;
      wr_data = new_cnt;
    end
  end

  always_comb begin
    cfg_seed = cfg_data_i[SeedW-1:0];
    if (cfg_seed == '0) begin
      cfg_seed = SeedW'(1);
    end else if (cfg_seed > MaxSeed) begin
      cfg_seed = MaxSeed;
    end
    cfg_limit = (cfg_data_i[CountW-1:0] > HardCountCap) ? HardCountCap
                                                        : cfg_data_i[CountW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rdata_q   <= mem[rd_addr];
      s1_op_q   <= op_d;
      s1_addr_q <= rd_addr;
    end
    if (s1_fire) begin
      out_q      <= res;
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SeedRstEff;
      limit_q     <= LimitRst;
      shift_q     <= '0;
      seen_q      <= '0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_SEED_LENGTH: seed_q  <= cfg_seed;
          CFG_COUNT_LIMIT: limit_q <= cfg_limit;
          default: ;
        endcase
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == {AddrW{1'b1}}) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_fire && (in_data_i.action == ACT_ADD)) begin
        shift_q <= shift_d;
        seen_q  <= seen_d;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        fwd_valid_q <= s1_write;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ready_o)
    else $error("input accepted during table clear");

  a_stalled_read_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> $stable(rdata_q) && $stable(s1_addr_q))
    else $error("modify stage lost its read data while stalled");

  a_limit_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.at_limit) |-> out_data_o.kmer_valid)
    else $error("at_limit set on an empty result");

endmodule

`default_nettype wire
